/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define JES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define JES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/jes_pkg.sv */
// ----------------------------------------------------------------------------
// jes_pkg
// Types and constants shared by the Exif segment stripper modules.
// ----------------------------------------------------------------------------
package jes_pkg;

  localparam int SigBytes = 6;
  localparam int CmdBytes = 4 + SigBytes;
  localparam int CntW     = $clog2(CmdBytes + 1);
  localparam int IdxW     = $clog2(CmdBytes);
  localparam int SigIdxW  = $clog2(SigBytes);
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  localparam logic [7:0] MarkPrefix = 8'hFF;
  localparam logic [7:0] MarkSoi    = 8'hD8;
  localparam logic [7:0] MarkSos    = 8'hDA;
  localparam logic [7:0] MarkEoi    = 8'hD9;
  localparam logic [7:0] MarkTem    = 8'h01;
  localparam logic [7:0] MarkStuff  = 8'h00;
  localparam logic [7:0] MarkRst0   = 8'hD0;
  localparam logic [7:0] MarkRst7   = 8'hD7;
  localparam logic [7:0] MarkApp1   = 8'hE1;
  localparam logic [15:0] MinLen    = 16'd2;
  localparam logic [15:0] MinExifLen = 16'd8;

  localparam logic [SigBytes-1:0][7:0] ExifSig = {8'h00, 8'h00, 8'h66, 8'h69, 8'h78, 8'h45};

  typedef enum logic [3:0] {
    PhSoi0,
    PhSoi1,
    PhMark0,
    PhMark1,
    PhLen0,
    PhLen1,
    PhSig,
    PhBody,
    PhCopy,
    PhStop,
    PhInvalid
  } phase_e;

  // One command holds every result that a single input item releases.
  typedef struct packed {
    logic [CmdBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
    logic                     last;
    logic                     status;
  } cmd_t;

endpackage

/* rtl/jes_front.sv */
// ----------------------------------------------------------------------------
// jes_front
// Marker parser: accepts one byte per cycle while the queue has room and turns
// it into a command listing the bytes to release, holding headers until decided.
// ----------------------------------------------------------------------------
module jes_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  logic [7:0]    s_tdata_i,
  input  logic          s_tlast_i,
  input  logic          q_full_i,
  output logic          push_o,
  output jes_pkg::cmd_t cmd_o
);
  import jes_pkg::*;

  phase_e                   ph_q, ph_d;
  logic [7:0]               marker_q, marker_d;
  logic [15:0]              len_q, len_d;
  logic [15:0]              left_q, left_d;
  logic [SigIdxW-1:0]       sigcnt_q, sigcnt_d;
  logic                     drop_q, drop_d;
  logic                     stat_q, stat_d;
  logic [SigBytes-1:0][7:0] sig_q, sig_new;

  logic                     acc;
  logic [7:0]               b;
  logic [15:0]              len_new;
  logic [15:0]              left_dec;
  logic [SigIdxW-1:0]       sigcnt_new;
  logic [CmdBytes-1:0][7:0] hdr;
  cmd_t                     cmd;

  assign s_tready_o = !q_full_i;
  assign acc        = s_tvalid_i && s_tready_o;
  assign b          = s_tdata_i;
  assign len_new    = {len_q[15:8], b};
  assign left_dec   = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;
  assign sigcnt_new = sigcnt_q + SigIdxW'(1);

  always_comb begin
    sig_new = sig_q;
    sig_new[sigcnt_q] = b;
  end

  always_comb begin
    ph_d     = ph_q;
    marker_d = marker_q;
    len_d    = len_q;
    left_d   = left_q;
    sigcnt_d = sigcnt_q;
    drop_d   = drop_q;
    stat_d   = stat_q;
    cmd      = '0;
    hdr      = '0;
    if (acc) begin
      case (ph_q)
        PhSoi0: begin
          if (b == MarkPrefix) begin
            ph_d = PhSoi1;
          end else begin
            stat_d = 1'b1;
            ph_d   = PhInvalid;
          end
        end
        PhSoi1: begin
          if (b == MarkSoi) begin
            cmd.bytes[0] = MarkPrefix;
            cmd.bytes[1] = b;
            cmd.cnt      = CntW'(2);
            ph_d         = PhMark0;
          end else begin
            stat_d = 1'b1;
            ph_d   = PhInvalid;
          end
        end
        PhMark0: begin
          ph_d = (b == MarkPrefix) ? PhMark1 : PhStop;
        end
        PhMark1: begin
          marker_d = b;
          if (b == MarkSos || b == MarkEoi || b == MarkStuff || b == MarkTem ||
              (b >= MarkRst0 && b <= MarkRst7)) begin
            cmd.bytes[0] = MarkPrefix;
            cmd.bytes[1] = b;
            cmd.cnt      = CntW'(2);
            if (b == MarkSos) begin
              ph_d = PhCopy;
            end else if (b == MarkEoi) begin
              ph_d = PhStop;
            end else begin
              ph_d = PhMark0;
            end
          end else begin
            ph_d = PhLen0;
          end
        end
        PhLen0: begin
          len_d = {b, 8'h00};
          ph_d  = PhLen1;
        end
        PhLen1: begin
          len_d = len_new;
          if (len_new < MinLen) begin
            ph_d = PhStop;
          end else begin
            left_d = len_new - MinLen;
            drop_d = 1'b0;
            if (marker_q == MarkApp1 && len_new >= MinExifLen) begin
              sigcnt_d = '0;
              ph_d     = PhSig;
            end else begin
              cmd.cnt = CntW'(4);
              ph_d    = (left_d != 16'd0) ? PhBody : PhMark0;
            end
          end
        end
        PhSig: begin
          left_d = left_dec;
          if (sigcnt_new == SigIdxW'(SigBytes)) begin
            if (sig_new == ExifSig) begin
              drop_d = 1'b1;
            end else begin
              drop_d  = 1'b0;
              cmd.cnt = CntW'(CmdBytes);
            end
            sigcnt_d = '0;
            ph_d     = (left_dec != 16'd0) ? PhBody : PhMark0;
          end else begin
            sigcnt_d = sigcnt_new;
          end
        end
        PhBody: begin
          if (!drop_q) begin
            cmd.bytes[0] = b;
            cmd.cnt      = CntW'(1);
          end
          left_d = left_dec;
          if (left_dec == 16'd0) begin
            ph_d = PhMark0;
          end
        end
        PhCopy: begin
          cmd.bytes[0] = b;
          cmd.cnt      = CntW'(1);
        end
        default: begin
        end
      endcase

      if (s_tlast_i) begin
        if (ph_d == PhSoi1) begin
          stat_d = 1'b1;
        end
        if (ph_d == PhSig) begin
          cmd.cnt = (ph_q == PhSig) ? CntW'(4) + CntW'(sigcnt_new) : CntW'(4);
        end
      end

      // A held-back header, optionally followed by the collected signature.
      hdr[0] = MarkPrefix;
      hdr[1] = marker_q;
      hdr[2] = len_d[15:8];
      hdr[3] = len_d[7:0];
      for (int i = 0; i < SigBytes; i++) begin
        hdr[4 + i] = sig_new[i];
      end
      if (ph_q == PhLen1 || ph_q == PhSig) begin
        cmd.bytes = hdr;
      end
      cmd.last   = s_tlast_i;
      cmd.status = stat_d;

      if (s_tlast_i) begin
        ph_d     = PhSoi0;
        marker_d = '0;
        len_d    = '0;
        left_d   = '0;
        sigcnt_d = '0;
        drop_d   = 1'b0;
        stat_d   = 1'b0;
      end
    end
  end

  assign push_o = acc && (cmd.cnt != '0 || s_tlast_i);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PhSoi0;
      marker_q <= '0;
      len_q    <= '0;
      left_q   <= '0;
      sigcnt_q <= '0;
      drop_q   <= 1'b0;
      stat_q   <= 1'b0;
    end else begin
      ph_q     <= ph_d;
      marker_q <= marker_d;
      len_q    <= len_d;
      left_q   <= left_d;
      sigcnt_q <= sigcnt_d;
      drop_q   <= drop_d;
      stat_q   <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && ph_q == PhSig) begin
      sig_q <= sig_new;
    end
  end

endmodule

/* rtl/jes_queue.sv */
// ----------------------------------------------------------------------------
// jes_queue
// Short command queue between the parser and the output emitter.
// ----------------------------------------------------------------------------
module jes_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jes_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output jes_pkg::cmd_t cmd_o
);
  import jes_pkg::*;
  `include "assert_macros.svh"

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + QPtrW'(1) : wptr_q;
    rptr_d = pop_i ? rptr_q + QPtrW'(1) : rptr_q;
    cnt_d  = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  `JES_ASSERT(a_no_overflow, push_i |-> !full_o, "command pushed into a full queue")
  `JES_ASSERT(a_no_underflow, pop_i |-> valid_o, "command popped from an empty queue")

endmodule

/* rtl/jes_back.sv */
// ----------------------------------------------------------------------------
// jes_back
// Output emitter: walks the head command one result per cycle into the
// output register while the output is not stalled by m_tready.
// ----------------------------------------------------------------------------
module jes_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  jes_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output logic [7:0]    m_tdata_o,
  output logic [1:0]    m_tuser_o,
  output logic          m_tlast_o
);
  import jes_pkg::*;
  `include "assert_macros.svh"

  logic [IdxW-1:0] idx_q, idx_d;
  logic            vld_q;
  logic [7:0]      data_q;
  logic            byte_q;
  logic            last_q;
  logic            stat_q;
  logic            load;
  logic            bare;
  logic            final_res;

  assign load      = q_valid_i && (!vld_q || m_tready_i);
  assign bare      = (cmd_i.cnt == '0);
  assign final_res = bare || (CntW'(idx_q) + CntW'(1) == cmd_i.cnt);
  assign pop_o     = load && final_res;

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = final_res ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        vld_q <= 1'b1;
      end else if (m_tready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= bare ? 8'h00 : cmd_i.bytes[idx_q];
      byte_q <= !bare;
      last_q <= final_res && cmd_i.last;
      stat_q <= final_res && cmd_i.last && cmd_i.status;
    end
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = {stat_q, byte_q};
  assign m_tlast_o  = last_q;

  `JES_ASSERT(a_bare_is_last, (vld_q && !byte_q) |-> last_q,
              "bare result without end of file")
  `JES_ASSERT(a_status_on_last, (vld_q && stat_q) |-> last_q,
              "status raised on a result that is not the last")
  `JES_ASSERT_NEXT(a_idx_restart, pop_o, idx_q == '0,
                   "result index not restarted after a command")

endmodule

/* rtl/jpeg_exif_segment_stripper.sv */
// ----------------------------------------------------------------------------
// jpeg_exif_segment_stripper
// Passes a JPEG file through byte by byte and removes Exif APP1 segments.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle while its four-entry command queue
// has room, and gives one result per cycle from its output register while
// m_axis_tready is high. Most bytes release zero or one result, a marker
// releases two, and the byte that settles a held-back segment header releases
// up to ten (FF, marker, two length bytes and six signature bytes), so the
// output side sets the pace there. A bare result with tuser bit 0 low ends a
// file that produced no final byte.
module jpeg_exif_segment_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_byte
  output logic [1:0] m_axis_tuser,  // [0] out_valid, [1] status
  output logic       m_axis_tlast
);
  import jes_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  jes_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .q_full_i   (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  jes_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  jes_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

/* tb/jpeg_exif_segment_stripper_tb.sv */
// ----------------------------------------------------------------------------
// jpeg_exif_segment_stripper_tb
// Sends short JPEG-like files through the stripper and predicts each filtered
// byte, end marker and status, then compares every result item in order.
// ----------------------------------------------------------------------------
module jpeg_exif_segment_stripper_tb;
  import jes_pkg::*;

  localparam int unsigned RandomBytes = 500;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StallLimit  = 3000;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       is_last;
    logic       status;
  } strip_result_t;

  class exif_strip_scoreboard;
    strip_result_t expected_q[$];
    phase_e        phase;
    logic [7:0]    marker;
    logic [15:0]   seg_len;
    logic [15:0]   remaining;
    logic [7:0]    sig_buf[SigBytes];
    int unsigned   sig_cnt;
    logic          drop_seg;
    logic          bad_start;
    logic [7:0]    released_q[$];
    int unsigned   errors;
    int unsigned   checked;
    int unsigned   files;
    int unsigned   bad_files;
    int unsigned   exif_removed;

    function new();
      errors       = 0;
      checked      = 0;
      files        = 0;
      bad_files    = 0;
      exif_removed = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase     = PhSoi0;
      marker    = 8'h00;
      seg_len   = 16'h0000;
      remaining = 16'h0000;
      sig_cnt   = 0;
      drop_seg  = 1'b0;
      bad_start = 1'b0;
    endfunction

    // Header bytes plus whatever part of the signature has been collected.
    function void release_held();
      released_q.push_back(MarkPrefix);
      released_q.push_back(marker);
      released_q.push_back(seg_len[15:8]);
      released_q.push_back(seg_len[7:0]);
      for (int k = 0; k < int'(sig_cnt) && k < SigBytes; k++) begin
        released_q.push_back(sig_buf[k]);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic is_last);
      strip_result_t r;
      logic          matched;
      logic          bare;
      released_q.delete();
      case (phase)
        PhSoi0: begin
          if (b == MarkPrefix) begin
            phase = PhSoi1;
          end else begin
            bad_start = 1'b1;
            phase     = PhInvalid;
          end
        end
        PhSoi1: begin
          if (b == MarkSoi) begin
            released_q.push_back(MarkPrefix);
            released_q.push_back(MarkSoi);
            phase = PhMark0;
          end else begin
            bad_start = 1'b1;
            phase     = PhInvalid;
          end
        end
        PhMark0: begin
          phase = (b == MarkPrefix) ? PhMark1 : PhStop;
        end
        PhMark1: begin
          marker = b;
          if (b == MarkSos) begin
            released_q.push_back(MarkPrefix);
            released_q.push_back(b);
            phase = PhCopy;
          end else if (b == MarkEoi) begin
            released_q.push_back(MarkPrefix);
            released_q.push_back(b);
            phase = PhStop;
          end else if (b == MarkStuff || b == MarkTem || (b >= MarkRst0 && b <= MarkRst7)) begin
            released_q.push_back(MarkPrefix);
            released_q.push_back(b);
            phase = PhMark0;
          end else begin
            phase = PhLen0;
          end
        end
        PhLen0: begin
          seg_len = {b, 8'h00};
          phase   = PhLen1;
        end
        PhLen1: begin
          seg_len[7:0] = b;
          if (seg_len < MinLen) begin
            phase = PhStop;
          end else begin
            remaining = seg_len - MinLen;
            drop_seg  = 1'b0;
            if (marker == MarkApp1 && seg_len >= MinExifLen) begin
              sig_cnt = 0;
              phase   = PhSig;
            end else begin
              release_held();
              phase = (remaining != 0) ? PhBody : PhMark0;
            end
          end
        end
        PhSig: begin
          if (sig_cnt < SigBytes) begin
            sig_buf[sig_cnt] = b;
            sig_cnt++;
          end
          if (remaining != 0) remaining--;
          if (sig_cnt >= SigBytes) begin
            matched = 1'b1;
            for (int k = 0; k < SigBytes; k++) begin
              if (sig_buf[k] != ExifSig[k]) matched = 1'b0;
            end
            if (matched) begin
              drop_seg = 1'b1;
              exif_removed++;
            end else begin
              drop_seg = 1'b0;
              release_held();
            end
            sig_cnt = 0;
            phase   = (remaining != 0) ? PhBody : PhMark0;
          end
        end
        PhBody: begin
          if (!drop_seg) released_q.push_back(b);
          if (remaining != 0) remaining--;
          if (remaining == 0) phase = PhMark0;
        end
        PhCopy: begin
          released_q.push_back(b);
        end
        default: begin
        end
      endcase

      if (is_last) begin
        if (phase == PhSoi1) bad_start = 1'b1;
        if (phase == PhSig) release_held();
      end

      bare = is_last && released_q.size() == 0;
      if (bare) released_q.push_back(8'h00);
      foreach (released_q[i]) begin
        r.data    = released_q[i];
        r.valid   = !bare;
        r.is_last = is_last && (i == released_q.size() - 1);
        r.status  = r.is_last && bad_start;
        expected_q.push_back(r);
      end

      if (is_last) begin
        files++;
        if (bad_start) bad_files++;
        clear_state();
      end
    endfunction

    function void check_output(logic [7:0] data, logic [1:0] user, logic is_last);
      strip_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        $error("Unexpected result item: out_byte %02h tuser %b tlast %b", data, user, is_last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data) begin
        $error("out_byte mismatch: expected %02h, actual %02h", want.data, data);
        errors++;
      end
      if (user[0] !== want.valid) begin
        $error("out_valid mismatch: expected %b, actual %b", want.valid, user[0]);
        errors++;
      end
      if (user[1] !== want.status) begin
        $error("status mismatch: expected %b, actual %b", want.status, user[1]);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $error("out_last mismatch: expected %b, actual %b", want.is_last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic [1:0] m_axis_tuser;           // [0] out_valid, [1] status
  logic       m_axis_tlast;

  exif_strip_scoreboard sb = new();
  logic [7:0]           file_q[$];
  int unsigned          bytes_in = 0;
  bit                   quiet    = 1'b0;

  jpeg_exif_segment_stripper dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if (!quiet && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, is_last);
    bytes_in++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
  endtask

  function automatic void build_random_file();
    int unsigned segs;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  mk;
    logic [7:0]  sig[SigBytes];
    file_q.delete();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom));
      return;
    end
    file_q.push_back(MarkPrefix);
    file_q.push_back(($urandom_range(99) < 4) ? 8'($urandom) : MarkSoi);
    segs = $urandom_range(0, 4);
    repeat (segs) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          len = $urandom_range(8, 12);
          for (int k = 0; k < SigBytes; k++) sig[k] = ExifSig[k];
          if ($urandom_range(0, 1) == 1) begin
            sig[$urandom_range(0, SigBytes - 1)] ^= 8'($urandom_range(1, 255));
          end
          file_q.push_back(MarkPrefix);
          file_q.push_back(MarkApp1);
          file_q.push_back(8'h00);
          file_q.push_back(8'(len));
          for (int k = 0; k < SigBytes; k++) file_q.push_back(sig[k]);
          repeat (len - 8) file_q.push_back(8'($urandom));
        end
        2, 3: begin
          mk  = ($urandom_range(0, 1) == 1) ? MarkApp1 : 8'($urandom_range(8'hC0, 8'hFE));
          len = $urandom_range(2, 7);
          file_q.push_back(MarkPrefix);
          file_q.push_back(mk);
          file_q.push_back(8'h00);
          file_q.push_back(8'(len));
          repeat (len - 2) file_q.push_back(8'($urandom));
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       mk = MarkStuff;
            1:       mk = MarkTem;
            default: mk = MarkRst0 + 8'($urandom_range(0, 7));
          endcase
          file_q.push_back(MarkPrefix);
          file_q.push_back(mk);
        end
      endcase
    end
    case ($urandom_range(0, 5))
      0, 1: begin
        file_q.push_back(MarkPrefix);
        file_q.push_back(MarkSos);
        repeat ($urandom_range(0, 8)) begin
          file_q.push_back(($urandom_range(0, 3) == 0) ? MarkPrefix : 8'($urandom));
        end
      end
      2: begin
        file_q.push_back(MarkPrefix);
        file_q.push_back(MarkEoi);
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
      end
      3: begin
        file_q.push_back(8'($urandom_range(0, 254)));
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
      end
      4: begin
        file_q.push_back(MarkPrefix);
        file_q.push_back(8'($urandom_range(8'hC0, 8'hEF)));
        file_q.push_back(8'h00);
        file_q.push_back(8'($urandom_range(0, 1)));
        file_q.push_back(8'($urandom));
      end
      default: begin
        file_q.push_back(MarkPrefix);
        file_q.push_back(($urandom_range(0, 1) == 1) ? MarkApp1 : 8'($urandom));
        file_q.push_back(8'($urandom));
        file_q.push_back(8'($urandom));
        repeat ($urandom_range(0, 7)) file_q.push_back(8'($urandom));
      end
    endcase
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endfunction

  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
      if (!held && sb.checked >= 120) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 9);
      end
    end
  end

  initial begin : watchdog
    int unsigned still;
    still = 0;
    while (still < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        still = 0;
      end else begin
        still++;
      end
    end
    $error("No item moved for %0d cycles", StallLimit);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned base;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Exif segment removed with its body, then stuffing, restart and scan data.
    file_q = '{MarkPrefix, MarkSoi, MarkPrefix, MarkApp1, 8'h00, 8'h09,
               ExifSig[0], ExifSig[1], ExifSig[2], ExifSig[3], ExifSig[4], ExifSig[5],
               8'hAA, MarkPrefix, MarkStuff, MarkPrefix, MarkRst7, MarkPrefix, MarkSos,
               8'h12, MarkPrefix};
    send_file();
    // Signature that differs in its last byte is kept; bytes after EOI vanish.
    file_q = '{MarkPrefix, MarkSoi, MarkPrefix, MarkApp1, 8'h00, 8'h08,
               ExifSig[0], ExifSig[1], ExifSig[2], ExifSig[3], ExifSig[4], 8'h01,
               MarkPrefix, MarkEoi, 8'h55};
    send_file();
    // Empty segment, standalone markers, then a stray byte at a boundary.
    file_q = '{MarkPrefix, MarkSoi, MarkPrefix, 8'hC0, 8'h00, 8'h02, MarkPrefix, MarkTem,
               MarkPrefix, MarkRst0, 8'h33, 8'h44};
    send_file();
    file_q = '{MarkPrefix, MarkSoi, MarkPrefix, 8'hE0, 8'h00, 8'h01, 8'h9A};
    send_file();
    file_q = '{8'h00};
    send_file();
    file_q = '{MarkPrefix, MarkPrefix, 8'h7E};
    send_file();
    file_q = '{MarkPrefix};
    send_file();
    // APP1 with the largest length, cut off inside its signature.
    file_q = '{MarkPrefix, MarkSoi, MarkPrefix, MarkApp1, 8'hFF, 8'hFF,
               ExifSig[0], ExifSig[1]};
    send_file();
    file_q = '{MarkPrefix, MarkSoi, MarkPrefix};
    send_file();
    file_q = '{MarkPrefix, MarkSoi, MarkPrefix, 8'hE2, 8'h00};
    send_file();

    base = bytes_in;
    while (bytes_in - base < RandomBytes) begin
      quiet = (bytes_in - base >= 200) && (bytes_in - base < 320);
      build_random_file();
      send_file();
    end
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d files (%0d bytes, %0d without a valid start of image).",
             sb.files, bytes_in, sb.bad_files);
    $display("Checked %0d result items; %0d Exif segments were removed.",
             sb.checked, sb.exif_removed);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/jes_pkg.sv
rtl/jes_front.sv
rtl/jes_queue.sv
rtl/jes_back.sv
rtl/jpeg_exif_segment_stripper.sv
tb/jpeg_exif_segment_stripper_tb.sv
